// ----- hdl/lis_pkg.sv -----
// Package for the longest-increasing-subsequence length block.
// Default sizes for the tails store and value width; no dependencies.
package lis_pkg;

  localparam int LIS_DEPTH_DEF      = 1024;
  localparam int LIS_VALUE_BITS_DEF = 32;

endpackage

// ----- hdl/lis_ram.sv -----
// Generic single-port synchronous RAM with registered read data.
// No dependencies; used for the tails store.
module lis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ----- hdl/lis_srch.sv -----
// Sequencer for the tails store: last-tail check, binary search, write-back,
// running length / overflow state and the result register. Uses lis_pkg.
module lis_srch import lis_pkg::*; #(
  parameter int DEPTH      = LIS_DEPTH_DEF,
  parameter int VALUE_BITS = LIS_VALUE_BITS_DEF,
  localparam int AW        = $clog2(DEPTH),
  localparam int CW        = $clog2(DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [VALUE_BITS-1:0] in_value,
  input  logic                         in_last,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [CW-1:0]                out_length,
  output logic                         out_overflow,
  output logic                         out_end_of_sequence,
  output logic                         ram_en,
  output logic                         ram_we,
  output logic [AW-1:0]                ram_addr,
  output logic [VALUE_BITS-1:0]        ram_wdata,
  input  logic [VALUE_BITS-1:0]        ram_rdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LAST,
    S_SRCH,
    S_DONE
  } state_t;

  state_t                state_r;
  logic [VALUE_BITS-1:0] key_r;
  logic                  last_r;
  logic [CW-1:0]         cnt_r;
  logic                  ovf_r;
  logic [AW-1:0]         lo_r;
  logic [AW-1:0]         hi_r;
  logic [AW-1:0]         mid_r;
  logic                  out_valid_r;
  logic [CW-1:0]         out_length_r;
  logic                  out_overflow_r;
  logic                  out_eos_r;

  logic [VALUE_BITS-1:0] in_key;
  logic [CW-1:0]         cnt_dec;
  logic [AW-1:0]         cnt_m1;
  logic                  full;
  logic                  above_last;
  logic                  mid_below;
  logic [AW-1:0]         lo_nxt;
  logic [AW-1:0]         hi_nxt;
  logic [AW-1:0]         mid_nxt;
  logic                  res_load;

  // Order key: flipping the sign bit makes unsigned compare match signed order.
  assign in_key     = {~in_value[VALUE_BITS-1], in_value[VALUE_BITS-2:0]};
  assign cnt_dec    = cnt_r - CW'(1);
  assign cnt_m1     = cnt_dec[AW-1:0];
  assign full       = (cnt_r == CW'(DEPTH));
  assign above_last = (key_r > ram_rdata);
  assign mid_below  = (ram_rdata < key_r);
  assign lo_nxt     = mid_below ? (mid_r + AW'(1)) : lo_r;
  assign hi_nxt     = mid_below ? hi_r : mid_r;
  assign mid_nxt    = lo_nxt + ((hi_nxt - lo_nxt) >> 1);
  assign res_load   = !out_valid_r || !out_stall;

  assign in_stall            = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_length          = out_length_r;
  assign out_overflow        = out_overflow_r;
  assign out_end_of_sequence = out_eos_r;

  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = '0;
    ram_wdata = key_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ram_en = 1'b1;
          if (cnt_r == '0) begin
            ram_we    = 1'b1;
            ram_wdata = in_key;
          end else begin
            ram_addr = cnt_m1;
          end
        end
      end
      S_LAST: begin
        if (above_last) begin
          if (!full) begin
            ram_en   = 1'b1;
            ram_we   = 1'b1;
            ram_addr = cnt_r[AW-1:0];
          end
        end else if (cnt_m1 == '0) begin
          ram_en = 1'b1;
          ram_we = 1'b1;
        end else begin
          ram_en   = 1'b1;
          ram_addr = cnt_m1 >> 1;
        end
      end
      S_SRCH: begin
        ram_en = 1'b1;
        if (lo_nxt == hi_nxt) begin
          ram_we   = 1'b1;
          ram_addr = lo_nxt;
        end else begin
          ram_addr = mid_nxt;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // in S_DONE the result register is reloaded below instead
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            key_r  <= in_key;
            last_r <= in_last;
            if (cnt_r == '0) begin
              cnt_r   <= CW'(1);
              state_r <= S_DONE;
            end else begin
              state_r <= S_LAST;
            end
          end
        end
        S_LAST: begin
          if (above_last) begin
            if (!full) begin
              cnt_r <= cnt_r + CW'(1);
            end else begin
              ovf_r <= 1'b1;
            end
            state_r <= S_DONE;
          end else if (cnt_m1 == '0) begin
            state_r <= S_DONE;
          end else begin
            // answer lies in [0, count-1]: last tail is known >= key
            lo_r    <= '0;
            hi_r    <= cnt_m1;
            mid_r   <= cnt_m1 >> 1;
            state_r <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (lo_nxt == hi_nxt) begin
            state_r <= S_DONE;
          end else begin
            lo_r  <= lo_nxt;
            hi_r  <= hi_nxt;
            mid_r <= mid_nxt;
          end
        end
        S_DONE: begin
          if (res_load) begin
            out_valid_r    <= 1'b1;
            out_length_r   <= cnt_r;
            out_overflow_r <= ovf_r;
            out_eos_r      <= last_r;
            if (last_r) begin
              cnt_r <= '0;
              ovf_r <= 1'b0;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hdl/lis_length_tails_binary_search.sv -----
// Running longest strictly increasing subsequence length (patience method).
// Each request carries one signed value; one result with the running length
// follows. Tails live in a single-port RAM of DEPTH entries. The first request
// of a sequence is written as the only tail. Later requests read the last
// tail first: a value above it is appended, or dropped with the overflow flag
// set when the store is full; otherwise, at a running length of 1, it replaces
// that tail, and at 2 or more a binary search over the RAM port finds the tail
// that it replaces. A stalled output register holds a request in its final
// state. A finished result waits in the output register while the next request
// is taken. No clearing pass after reset is needed.
// Depends on lis_pkg, lis_ram and lis_srch.
module lis_length_tails_binary_search import lis_pkg::*; #(
  parameter int DEPTH      = LIS_DEPTH_DEF,
  parameter int VALUE_BITS = LIS_VALUE_BITS_DEF,
  localparam int AW        = $clog2(DEPTH),
  localparam int CW        = $clog2(DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [VALUE_BITS-1:0] in_value,
  input  logic                         in_last,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [CW-1:0]                out_length,
  output logic                         out_overflow,
  output logic                         out_end_of_sequence
);

  logic                  ram_en;
  logic                  ram_we;
  logic [AW-1:0]         ram_addr;
  logic [VALUE_BITS-1:0] ram_wdata;
  logic [VALUE_BITS-1:0] ram_rdata;

  lis_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH)
  ) u_tails (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  lis_srch #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_srch (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_value            (in_value),
    .in_last             (in_last),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_length          (out_length),
    .out_overflow        (out_overflow),
    .out_end_of_sequence (out_end_of_sequence),
    .ram_en              (ram_en),
    .ram_we              (ram_we),
    .ram_addr            (ram_addr),
    .ram_wdata           (ram_wdata),
    .ram_rdata           (ram_rdata)
  );

endmodule
